>>> design/angle_tracking_pll_observer_top_defines.svh
`ifndef ANGLE_TRACKING_PLL_OBSERVER_TOP_DEFINES_SVH
`define ANGLE_TRACKING_PLL_OBSERVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ATPO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ATPO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/atpo_pkg.sv
`default_nettype none

package atpo_pkg;

    // Default geometry: encoder resolution and fractional bits of the estimates
    localparam int ANGLE_BITS_DEF = 14;
    localparam int FRAC_BITS_DEF  = 16;

    // Register field widths
    localparam int PROP_W  = 18;
    localparam int INTEG_W = 24;
    localparam int GATE_W  = 14;
    localparam int LIMIT_W = 8;
    localparam int TURNS_W = 32;

    // Binary points of the gains
    localparam int PROP_SHIFT  = 16;
    localparam int INTEG_SHIFT = 24;

    // Register port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [PROP_W-1:0]  PROP_GAIN_RST  = PROP_W'(8192);
    localparam logic [INTEG_W-1:0] INTEG_GAIN_RST = INTEG_W'(65536);
    localparam logic [GATE_W-1:0]  GATE_SPAN_RST  = GATE_W'(256);
    localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST = LIMIT_W'(5);

    // Operation codes of an input word
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_PREDICT = 1'b1;

    typedef enum logic [1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_GATE_SPAN  = 2'd2,
        REG_MISS_LIMIT = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_FIRST        = 3'd0,
        EV_LOCKED       = 3'd1,
        EV_CORRECTED    = 3'd2,
        EV_GATED        = 3'd3,
        EV_LOST         = 3'd4,
        EV_PREDICTED    = 3'd5,
        EV_PRED_IGNORED = 3'd6
    } t_event;

    typedef struct packed {
        logic [PROP_W-1:0]  prop_gain;
        logic [INTEG_W-1:0] integ_gain;
        logic [GATE_W-1:0]  gate_span;
        logic [LIMIT_W-1:0] miss_limit;
    } t_cfg;

endpackage

`default_nettype wire

>>> design/atpo_cfg.sv
`default_nettype none

module atpo_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [atpo_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [atpo_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [atpo_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output atpo_pkg::t_cfg                    o_cfg
);
    import atpo_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Take the low bits of the write data into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PROP_GAIN:  n_cfg.prop_gain  = pwdata[PROP_W-1:0];
                REG_INTEG_GAIN: n_cfg.integ_gain = pwdata[INTEG_W-1:0];
                REG_GATE_SPAN:  n_cfg.gate_span  = pwdata[GATE_W-1:0];
                REG_MISS_LIMIT: n_cfg.miss_limit = pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PROP_GAIN:  prdata = CFG_DATA_W'(r_cfg.prop_gain);
            REG_INTEG_GAIN: prdata = CFG_DATA_W'(r_cfg.integ_gain);
            REG_GATE_SPAN:  prdata = CFG_DATA_W'(r_cfg.gate_span);
            REG_MISS_LIMIT: prdata = CFG_DATA_W'(r_cfg.miss_limit);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= PROP_GAIN_RST;
            r_cfg.integ_gain <= INTEG_GAIN_RST;
            r_cfg.gate_span  <= GATE_SPAN_RST;
            r_cfg.miss_limit <= MISS_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/atpo_step.sv
`default_nettype none

module atpo_step #(
    parameter int ANGLE_BITS = atpo_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = atpo_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_op,
    input  logic [ANGLE_BITS-1:0]                i_raw,
    input  atpo_pkg::t_cfg                       i_cfg,
    input  logic [ANGLE_BITS+FRAC_BITS-1:0]      i_angle,
    input  logic [ANGLE_BITS+FRAC_BITS-1:0]      i_vel,
    input  logic [atpo_pkg::TURNS_W-1:0]         i_turns,
    input  logic                                 i_lock,
    input  logic                                 i_prev_valid,
    input  logic [ANGLE_BITS-1:0]                i_prev_raw,
    input  logic [atpo_pkg::LIMIT_W-1:0]         i_reject,
    input  logic [ANGLE_BITS-1:0]                i_innov,
    output logic [ANGLE_BITS+FRAC_BITS-1:0]      o_angle,
    output logic [ANGLE_BITS+FRAC_BITS-1:0]      o_vel,
    output logic [atpo_pkg::TURNS_W-1:0]         o_turns,
    output logic                                 o_lock,
    output logic                                 o_prev_valid,
    output logic [ANGLE_BITS-1:0]                o_prev_raw,
    output logic [atpo_pkg::LIMIT_W-1:0]         o_reject,
    output logic [ANGLE_BITS-1:0]                o_innov,
    output logic [ANGLE_BITS-1:0]                o_angle_out,
    output atpo_pkg::t_event                     o_event
);
    import atpo_pkg::*;

    localparam int POS_W = ANGLE_BITS + FRAC_BITS;
    localparam int ADV_W = POS_W + 2;
    localparam int KI_W  = POS_W + INTEG_W + 1;
    localparam int KP_W  = POS_W + PROP_W + 1;
    localparam int DI_W  = KI_W - INTEG_SHIFT;
    localparam int DP_W  = KP_W - PROP_SHIFT;
    localparam int VS_W  = POS_W + 2;
    localparam int S2_W  = DP_W + 1;
    localparam int GQ_W  = GATE_W + FRAC_BITS;
    localparam int CMP_W = (GQ_W > POS_W) ? GQ_W : POS_W;

    localparam logic [POS_W-1:0]      HALF_F   = POS_W'(1) << (FRAC_BITS - 1);
    localparam logic [KI_W-1:0]       KI_ROUND = KI_W'(1) << (INTEG_SHIFT - 1);
    localparam logic [KP_W-1:0]       KP_ROUND = KP_W'(1) << (PROP_SHIFT - 1);
    localparam logic [ANGLE_BITS-1:0] ERR_MAX  = {1'b0, {(ANGLE_BITS-1){1'b1}}};
    localparam logic [POS_W-1:0]      VEL_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]      VEL_MIN  = {1'b1, {(POS_W-1){1'b0}}};

    // Coast: angle plus velocity, whole turns taken from the top two bits
    logic [ADV_W-1:0]   sum1;
    logic [POS_W-1:0]   a1;
    logic [TURNS_W-1:0] turns1;

    assign sum1   = {2'b00, i_angle} + {{2{i_vel[POS_W-1]}}, i_vel};
    assign a1     = sum1[POS_W-1:0];
    assign turns1 = i_turns + {{(TURNS_W-ADV_W+POS_W){sum1[ADV_W-1]}}, sum1[ADV_W-1:POS_W]};

    // Innovation, wrapped to half a turn either way
    logic [POS_W-1:0]      err;
    logic                  err_neg;
    logic [POS_W-1:0]      err_mag;
    logic [POS_W-1:0]      err_rnd;
    logic [ANGLE_BITS-1:0] err_q;
    logic [ANGLE_BITS-1:0] err_cnt;
    logic                  gate_fail;

    assign err     = {i_raw, {FRAC_BITS{1'b0}}} - a1;
    assign err_neg = err[POS_W-1];
    assign err_mag = err_neg ? (~err + 1'b1) : err;
    assign err_rnd = err_mag + HALF_F;
    assign err_q   = err_rnd[POS_W-1:FRAC_BITS];
    // Round half away from zero; clip the single positive overflow
    assign err_cnt = err_neg ? (~err_q + 1'b1) : (err_q[ANGLE_BITS-1] ? ERR_MAX : err_q);

    assign gate_fail = CMP_W'(err_mag) > CMP_W'({i_cfg.gate_span, {FRAC_BITS{1'b0}}});

    logic [LIMIT_W-1:0] rc_inc;
    logic               lost;

    assign rc_inc = (i_reject == '1) ? i_reject : i_reject + 1'b1;
    assign lost   = rc_inc >= i_cfg.miss_limit;

    // Integral path: velocity correction, saturated
    logic signed [KI_W-1:0] prod_i;
    logic [KI_W-1:0]        rnd_i;
    logic [DI_W-1:0]        dv;
    logic [VS_W-1:0]        v_sum;
    logic [VS_W-POS_W:0]    v_top;
    logic                   v_ovf;
    logic [POS_W-1:0]       v_sat;

    assign prod_i = $signed(err) * $signed({1'b0, i_cfg.integ_gain});
    assign rnd_i  = prod_i + KI_ROUND;
    assign dv     = rnd_i[KI_W-1:INTEG_SHIFT];
    assign v_sum  = {{(VS_W-POS_W){i_vel[POS_W-1]}}, i_vel}
                  + {{(VS_W-DI_W){dv[DI_W-1]}}, dv};
    assign v_top  = v_sum[VS_W-1:POS_W-1];
    assign v_ovf  = !((v_top == '0) || (v_top == '1));
    assign v_sat  = v_ovf ? (v_sum[VS_W-1] ? VEL_MIN : VEL_MAX) : v_sum[POS_W-1:0];

    // Proportional path: angle correction, may cross several turns
    logic signed [KP_W-1:0] prod_p;
    logic [KP_W-1:0]        rnd_p;
    logic [DP_W-1:0]        dp;
    logic [S2_W-1:0]        sum2;
    logic [TURNS_W-1:0]     turns2;

    assign prod_p = $signed(err) * $signed({1'b0, i_cfg.prop_gain});
    assign rnd_p  = prod_p + KP_ROUND;
    assign dp     = rnd_p[KP_W-1:PROP_SHIFT];
    assign sum2   = {{(S2_W-POS_W){1'b0}}, a1} + {dp[DP_W-1], dp};
    assign turns2 = turns1 + {{(TURNS_W-S2_W+POS_W){sum2[S2_W-1]}}, sum2[S2_W-1:POS_W]};

    logic [ANGLE_BITS-1:0] acq_diff;
    assign acq_diff = i_raw - i_prev_raw;

    always_comb begin
        o_angle      = i_angle;
        o_vel        = i_vel;
        o_turns      = i_turns;
        o_lock       = i_lock;
        o_prev_valid = i_prev_valid;
        o_prev_raw   = i_prev_raw;
        o_reject     = i_reject;
        o_innov      = i_innov;
        o_event      = EV_PRED_IGNORED;
        if (i_op == OP_PREDICT) begin
            if (i_lock) begin
                o_angle = a1;
                o_turns = turns1;
                o_event = EV_PREDICTED;
            end
        end else if (!i_lock) begin
            if (i_prev_valid) begin
                o_vel   = {acq_diff, {FRAC_BITS{1'b0}}};
                o_angle = {i_raw, {FRAC_BITS{1'b0}}};
                o_turns = '0;
                o_lock  = 1'b1;
                o_event = EV_LOCKED;
            end else begin
                o_event = EV_FIRST;
            end
            o_prev_raw   = i_raw;
            o_prev_valid = 1'b1;
            o_innov      = '0;
        end else begin
            o_prev_raw = i_raw;
            o_angle    = a1;
            o_turns    = turns1;
            o_innov    = err_cnt;
            if (gate_fail) begin
                if (lost) begin
                    o_lock       = 1'b0;
                    o_prev_valid = 1'b0;
                    o_reject     = '0;
                    o_event      = EV_LOST;
                end else begin
                    o_reject = rc_inc;
                    o_event  = EV_GATED;
                end
            end else begin
                o_reject = '0;
                o_vel    = v_sat;
                o_angle  = sum2[POS_W-1:0];
                o_turns  = turns2;
                o_event  = EV_CORRECTED;
            end
        end
    end

    logic [POS_W-1:0] ang_rnd;
    assign ang_rnd     = o_angle + HALF_F;
    assign o_angle_out = ang_rnd[POS_W-1:FRAC_BITS];

endmodule

`default_nettype wire

>>> design/angle_tracking_pll_observer_top.sv
`default_nettype none
`include "angle_tracking_pll_observer_top_defines.svh"

// Type-II angle tracking observer for an absolute rotary encoder. Each input
// word is either a raw angle sample or a predict tick; each accepted word
// yields exactly one result word carrying the rounded angle, the signed turn
// count, the velocity in counts per sample (Q.FRAC_BITS), the last innovation
// in counts, the lock flag and an event code. Lock is gained over two samples
// and lost once the run of consecutive samples outside the gate reaches the
// reject limit. Throughput is one word per clock while i_out_stall is low: the
// whole update is combinational between the input stage and the result
// register, with the gain multipliers (error x integ_gain, error x prop_gain)
// and the wrap and saturation adders on that path. A result is registered
// when its word leaves the input stage and is held until it is taken.
// A result waiting on o_out_valid does not block the input stage, so one
// further word is taken while the output is stalled. Gains, gate and reject
// limit sit on the APB-style port at byte offsets 0, 4, 8 and 12 and should
// only be written while no word is in flight. ANGLE_BITS (8 to 16) and
// FRAC_BITS (8 to 24) set the encoder resolution and estimate precision.
module angle_tracking_pll_observer_top #(
    parameter int ANGLE_BITS = atpo_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = atpo_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [ANGLE_BITS-1:0]               i_raw_angle,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ANGLE_BITS-1:0]               o_angle_out,
    output logic signed [atpo_pkg::TURNS_W-1:0] o_turn_count,
    output logic signed [ANGLE_BITS+FRAC_BITS-1:0] o_velocity,
    output logic signed [ANGLE_BITS-1:0]        o_error_counts,
    output logic                                o_is_locked,
    output logic [2:0]                          o_event_code,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [atpo_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [atpo_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [atpo_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import atpo_pkg::*;

    localparam int POS_W = ANGLE_BITS + FRAC_BITS;

    t_cfg cfg;

    atpo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input stage: one word waiting for the update
    logic                  r_s1_valid;
    logic                  r_s1_op;
    logic [ANGLE_BITS-1:0] r_s1_raw;

    // Result stage
    logic                  r_s2_valid;
    logic [ANGLE_BITS-1:0] r_out_angle;
    logic [TURNS_W-1:0]    r_out_turns;
    logic [POS_W-1:0]      r_out_vel;
    logic [ANGLE_BITS-1:0] r_out_err;
    logic                  r_out_locked;
    t_event                r_out_event;

    // Observer state
    logic [POS_W-1:0]      r_angle;
    logic [POS_W-1:0]      r_vel;
    logic [TURNS_W-1:0]    r_turns;
    logic                  r_lock;
    logic                  r_prev_valid;
    logic [ANGLE_BITS-1:0] r_prev_raw;
    logic [LIMIT_W-1:0]    r_reject;
    logic [ANGLE_BITS-1:0] r_innov;

    logic [POS_W-1:0]      n_angle;
    logic [POS_W-1:0]      n_vel;
    logic [TURNS_W-1:0]    n_turns;
    logic                  n_lock;
    logic                  n_prev_valid;
    logic [ANGLE_BITS-1:0] n_prev_raw;
    logic [LIMIT_W-1:0]    n_reject;
    logic [ANGLE_BITS-1:0] n_innov;
    logic [ANGLE_BITS-1:0] n_angle_out;
    t_event                n_event;

    logic s2_free;
    logic step_en;

    // The result register frees up when empty or when its word is taken;
    // the input stage then moves on and the state is updated in that cycle.
    assign s2_free    = !r_s2_valid || !i_out_stall;
    assign step_en    = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;

    atpo_step #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_step (
        .i_op         (r_s1_op),
        .i_raw        (r_s1_raw),
        .i_cfg        (cfg),
        .i_angle      (r_angle),
        .i_vel        (r_vel),
        .i_turns      (r_turns),
        .i_lock       (r_lock),
        .i_prev_valid (r_prev_valid),
        .i_prev_raw   (r_prev_raw),
        .i_reject     (r_reject),
        .i_innov      (r_innov),
        .o_angle      (n_angle),
        .o_vel        (n_vel),
        .o_turns      (n_turns),
        .o_lock       (n_lock),
        .o_prev_valid (n_prev_valid),
        .o_prev_raw   (n_prev_raw),
        .o_reject     (n_reject),
        .o_innov      (n_innov),
        .o_angle_out  (n_angle_out),
        .o_event      (n_event)
    );

    // Control and observer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_angle      <= '0;
            r_vel        <= '0;
            r_turns      <= '0;
            r_lock       <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev_raw   <= '0;
            r_reject     <= '0;
            r_innov      <= '0;
        end else begin
            // Hold the input stage while its word cannot advance
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            // Advance the observer once per word that moves to the result stage
            if (step_en) begin
                r_angle      <= n_angle;
                r_vel        <= n_vel;
                r_turns      <= n_turns;
                r_lock       <= n_lock;
                r_prev_valid <= n_prev_valid;
                r_prev_raw   <= n_prev_raw;
                r_reject     <= n_reject;
                r_innov      <= n_innov;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_op  <= i_operation;
            r_s1_raw <= i_raw_angle;
        end
        if (step_en) begin
            r_out_angle  <= n_angle_out;
            r_out_turns  <= n_turns;
            r_out_vel    <= n_vel;
            r_out_err    <= n_innov;
            r_out_locked <= n_lock;
            r_out_event  <= n_event;
        end
    end

    assign o_out_valid    = r_s2_valid;
    assign o_angle_out    = r_out_angle;
    assign o_turn_count   = r_out_turns;
    assign o_velocity     = r_out_vel;
    assign o_error_counts = r_out_err;
    assign o_is_locked    = r_out_locked;
    assign o_event_code   = r_out_event;

    `ATPO_ASSERT_SAME(a_unlocked_no_rejects, i_clk, i_rst_n, !r_lock, r_reject == '0, "reject run kept while unlocked")
    `ATPO_ASSERT_SAME(a_lock_has_prev, i_clk, i_rst_n, r_lock, r_prev_valid, "locked without a stored sample")
    `ATPO_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !step_en, $stable(r_angle) && $stable(r_turns) && $stable(r_lock), "observer state moved without a word")
    `ATPO_ASSERT_SAME(a_event_unlocked, i_clk, i_rst_n, o_out_valid && (r_out_event == EV_LOST || r_out_event == EV_FIRST), !r_out_locked, "acquisition or loss event reported as locked")
    `ATPO_ASSERT_SAME(a_stall_needs_full, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_s2_valid, "input stalled with a free stage")

endmodule

`default_nettype wire

>>> tb/angle_tracking_pll_observer_top_tb.sv
`default_nettype none

module angle_tracking_pll_observer_top_tb;
    import atpo_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int AW          = ANGLE_BITS_DEF;
    localparam int FW          = FRAC_BITS_DEF;
    localparam int PW          = AW + FW;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 90;

    // One revolution and half a revolution in Q(AW).(FW)
    localparam longint REV_Q      = 64'sd1 <<< PW;
    localparam longint HALF_REV_Q = 64'sd1 <<< (PW - 1);
    localparam longint ERR_TOP    = (64'sd1 <<< (AW - 1)) - 1;

    typedef struct packed {
        logic          op;
        logic [AW-1:0] raw;
    } t_enc_word;

    typedef struct packed {
        logic [AW-1:0]      angle;
        logic [TURNS_W-1:0] turns;
        logic [PW-1:0]      vel;
        logic [AW-1:0]      err;
        logic               locked;
        t_event             ev;
    } t_obs_word;

    // Clock, reset and the ports of the block
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic          i_in_valid  = 1'b0;
    logic          o_in_stall;
    logic          i_operation = OP_SAMPLE;
    logic [AW-1:0] i_raw_angle = '0;

    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [AW-1:0]             o_angle_out;
    logic signed [TURNS_W-1:0] o_turn_count;
    logic signed [PW-1:0]      o_velocity;
    logic signed [AW-1:0]      o_error_counts;
    logic                      o_is_locked;
    logic [2:0]                o_event_code;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Words waiting to be driven, and observer results still owed by the block
    t_enc_word enc_words[$];
    t_obs_word pending_obs[$];

    int  feed_gap    = 0;
    int  stall_left  = 0;
    bit  word_taken  = 1'b0;
    bit  quiet_flow  = 1'b0;
    int  bad_words   = 0;
    int  cycle_count = 0;
    int  rotor_pos   = 0;
    int  rotor_speed = 0;

    // Observer state, mirrored from the block's own reset values
    longint             est_angle   = 0;
    longint             est_vel     = 0;
    logic [TURNS_W-1:0] rev_count   = '0;
    bit                 loop_locked = 1'b0;
    bit                 prev_seen   = 1'b0;
    logic [AW-1:0]      prev_sample = '0;
    int                 rejects     = 0;
    longint             last_innov  = 0;

    logic [PROP_W-1:0]  k_prop  = PROP_GAIN_RST;
    logic [INTEG_W-1:0] k_integ = INTEG_GAIN_RST;
    logic [GATE_W-1:0]  gate    = GATE_SPAN_RST;
    logic [LIMIT_W-1:0] rej_lim = MISS_LIMIT_RST;

    angle_tracking_pll_observer_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_raw_angle    (i_raw_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_angle_out    (o_angle_out),
        .o_turn_count   (o_turn_count),
        .o_velocity     (o_velocity),
        .o_error_counts (o_error_counts),
        .o_is_locked    (o_is_locked),
        .o_event_code   (o_event_code),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Fold a Q position difference into half a revolution either side of zero
    function automatic longint wrap_rev(longint d);
        longint u;
        u = d & (REV_Q - 1);
        return (u >= HALF_REV_Q) ? u - REV_Q : u;
    endfunction

    // Move the angle estimate; count every revolution crossed, floor-wise
    function automatic void rotate(longint delta);
        longint sum;
        sum = est_angle + delta;
        rev_count = rev_count + TURNS_W'(sum >>> PW);
        est_angle = sum & (REV_Q - 1);
    endfunction

    // Innovation to whole counts, half away from zero, top code saturated
    function automatic longint to_counts(longint e);
        longint r;
        if (e >= 0) begin
            r = (e + (64'sd1 <<< (FW - 1))) >>> FW;
        end else begin
            r = -((-e + (64'sd1 <<< (FW - 1))) >>> FW);
        end
        return (r > ERR_TOP) ? ERR_TOP : r;
    endfunction

    // Run one accepted word through the observer and queue the result it owes
    function automatic void observe_word(logic op, logic [AW-1:0] raw);
        longint    e;
        longint    gate_q;
        longint    v;
        longint    raw_q;
        t_event    ev;
        t_obs_word r;
        raw_q = longint'(raw) <<< FW;
        if (op == OP_PREDICT) begin
            if (loop_locked) begin
                rotate(est_vel);
                ev = EV_PREDICTED;
            end else begin
                ev = EV_PRED_IGNORED;
            end
        end else if (!loop_locked) begin
            // Acquisition: store the first sample, lock on the second
            if (prev_seen) begin
                est_vel     = wrap_rev(raw_q - (longint'(prev_sample) <<< FW));
                est_angle   = raw_q;
                rev_count   = '0;
                loop_locked = 1'b1;
                ev          = EV_LOCKED;
            end else begin
                ev = EV_FIRST;
            end
            prev_sample = raw;
            prev_seen   = 1'b1;
            last_innov  = 0;
        end else begin
            prev_sample = raw;
            rotate(est_vel);
            e          = wrap_rev(raw_q - est_angle);
            last_innov = to_counts(e);
            gate_q     = longint'(gate) <<< FW;
            if (e > gate_q || e < -gate_q) begin
                if (rejects < 255) rejects++;
                if (rejects >= int'(rej_lim)) begin
                    loop_locked = 1'b0;
                    prev_seen   = 1'b0;
                    rejects     = 0;
                    ev          = EV_LOST;
                end else begin
                    ev = EV_GATED;
                end
            end else begin
                rejects = 0;
                v = est_vel + ((e * longint'(k_integ) + (64'sd1 <<< (INTEG_SHIFT - 1)))
                               >>> INTEG_SHIFT);
                if (v > HALF_REV_Q - 1) v = HALF_REV_Q - 1;
                if (v < -HALF_REV_Q) v = -HALF_REV_Q;
                est_vel = v;
                rotate((e * longint'(k_prop) + (64'sd1 <<< (PROP_SHIFT - 1))) >>> PROP_SHIFT);
                ev = EV_CORRECTED;
            end
        end
        r.angle  = AW'((est_angle + (64'sd1 <<< (FW - 1))) >>> FW);
        r.turns  = rev_count;
        r.vel    = PW'(est_vel);
        r.err    = AW'(last_innov);
        r.locked = loop_locked;
        r.ev     = ev;
        pending_obs.push_back(r);
    endfunction

    // Idle length: mostly none, often short, now and then long; none in a quiet phase
    function automatic int idle_len();
        int k;
        k = $urandom_range(99);
        if (quiet_flow || k < 60) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_word(logic op, logic [AW-1:0] raw);
        enc_words.push_back({op, raw});
    endfunction

    // Samples of a rotor turning at a steady speed with a little noise; mixed with
    // predict ticks, lone outliers, outlier bursts that may break lock, and speed changes
    function automatic void queue_rotor(int n);
        int i;
        int j;
        int k;
        int noise;
        for (i = 0; i < n; i++) begin
            rotor_pos += rotor_speed;
            k = $urandom_range(99);
            if (k < 3) begin
                for (j = $urandom_range(2, 8); j > 0; j--) push_word(OP_SAMPLE, AW'($urandom));
            end else if (k < 9) begin
                push_word(OP_SAMPLE, AW'($urandom));
            end else if (k < 18) begin
                push_word(OP_PREDICT, AW'($urandom));
            end else begin
                if (k < 20) rotor_speed = int'($urandom_range(0, 400)) - 200;
                noise = int'($urandom_range(0, 6)) - 3;
                push_word(OP_SAMPLE, AW'(rotor_pos + noise));
            end
        end
    endfunction

    // Register write: setup cycle, then access until pready; mirror the value
    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN:  k_prop  = val[PROP_W-1:0];
            REG_INTEG_GAIN: k_integ = val[INTEG_W-1:0];
            REG_GATE_SPAN:  gate    = val[GATE_W-1:0];
            REG_MISS_LIMIT: rej_lim = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int kp, int ki, int kg, int kl);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_GATE_SPAN, kg);
        write_reg(REG_MISS_LIMIT, kl);
    endtask

    // Wait until every word is in and every result is out, then let the pipe empty
    task automatic drain_flow();
        while (enc_words.size() != 0 || i_in_valid || pending_obs.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Input driver: advance to the next word once the current one is taken, after
    // its gap; hold the payload untouched while the block stalls
    always @(negedge i_clk) begin : feed_words
        t_enc_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            if (feed_gap > 0) begin
                feed_gap   <= feed_gap - 1;
                i_in_valid <= 1'b0;
            end else if (enc_words.size() != 0) begin
                w = enc_words.pop_front();
                i_operation <= w.op;
                i_raw_angle <= w.raw;
                i_in_valid  <= 1'b1;
                feed_gap    <= idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: stall runs of random length between free cycles
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= ($urandom_range(3) == 0) ? idle_len() : 0;
        end
    end

    // Monitor: predict on every accepted input word, then check every accepted
    // result word against the oldest prediction
    always @(posedge i_clk) begin : watch_ports
        t_obs_word got;
        t_obs_word want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) observe_word(i_operation, i_raw_angle);
            if (o_out_valid && !i_out_stall) begin
                got.angle  = o_angle_out;
                got.turns  = o_turn_count;
                got.vel    = o_velocity;
                got.err    = o_error_counts;
                got.locked = o_is_locked;
                got.ev     = t_event'(o_event_code);
                if (pending_obs.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected result word: angle %0d turns %0d vel %0d err %0d lock %0b ev %0d",
                                 got.angle, $signed(got.turns), $signed(got.vel),
                                 $signed(got.err), got.locked, got.ev);
                end else begin
                    want = pending_obs.pop_front();
                    if (got !== want) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("mismatch expected: angle %0d turns %0d vel %0d err %0d lock %0b ev %0d",
                                     want.angle, $signed(want.turns), $signed(want.vel),
                                     $signed(want.err), want.locked, want.ev);
                            $display("         actual:   angle %0d turns %0d vel %0d err %0d lock %0b ev %0d",
                                     got.angle, $signed(got.turns), $signed(got.vel),
                                     $signed(got.err), got.locked, got.ev);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : run_test
        int p;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gains: ignored predict, acquisition across the wrap, predict,
        // corrections, a run of gated samples ending in loss of lock, then a lock
        // on a half-revolution step and predicts that roll the turn count back
        push_word(OP_PREDICT, '0);
        push_word(OP_SAMPLE, AW'(16383));
        push_word(OP_SAMPLE, AW'(0));
        push_word(OP_PREDICT, AW'(16383));
        push_word(OP_SAMPLE, AW'(2));
        push_word(OP_SAMPLE, AW'(3));
        push_word(OP_SAMPLE, AW'(4000));
        push_word(OP_SAMPLE, AW'(12000));
        push_word(OP_SAMPLE, AW'(8000));
        push_word(OP_SAMPLE, AW'(10000));
        push_word(OP_SAMPLE, AW'(9000));
        push_word(OP_PREDICT, AW'(5));
        push_word(OP_SAMPLE, AW'(0));
        push_word(OP_SAMPLE, AW'(8192));
        push_word(OP_PREDICT, '0);
        push_word(OP_PREDICT, '0);
        drain_flow();

        // Zero gate and zero reject limit: an exact hit passes, any miss drops lock
        write_all(PROP_GAIN_RST, INTEG_GAIN_RST, 0, 0);
        push_word(OP_SAMPLE, AW'(0));
        push_word(OP_SAMPLE, AW'(5));
        push_word(OP_SAMPLE, AW'(100));
        push_word(OP_SAMPLE, AW'(100));
        push_word(OP_SAMPLE, AW'(100));
        push_word(OP_SAMPLE, AW'(101));
        push_word(OP_PREDICT, AW'(100));
        drain_flow();

        // Random phases: defaults, maximum gains and reject limit, zero gains, then random settings
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: write_all(PROP_GAIN_RST, INTEG_GAIN_RST, GATE_SPAN_RST, MISS_LIMIT_RST);
                1: write_all((1 << PROP_W) - 1, (1 << INTEG_W) - 1, 8192, 255);
                2: write_all(0, 0, 1, 1);
                3: write_all($urandom_range(0, 40000), $urandom_range(0, 400000),
                             (1 << GATE_W) - 1, $urandom_range(1, 8));
                default: write_all($urandom_range(0, (1 << PROP_W) - 1),
                                   $urandom_range(0, (1 << INTEG_W) - 1),
                                   ($urandom_range(1) != 0) ? $urandom_range(0, 600)
                                                            : $urandom_range(0, 16383),
                                   $urandom_range(0, 255));
            endcase
            quiet_flow  = (p % 3 == 2);
            rotor_pos   = $urandom_range(0, 16383);
            rotor_speed = ($urandom_range(3) == 0) ? int'($urandom_range(0, 16383)) - 8192
                                                   : int'($urandom_range(0, 400)) - 200;
            queue_rotor(PHASE_WORDS);
            drain_flow();
        end

        if (bad_words == 0 && pending_obs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
